FILE: design/cfq_pkg.sv
// ----------------------------------------------------------------------------
// cfq_pkg
// Shared types, constants and helpers for the circular fifo queue core.
// ----------------------------------------------------------------------------
package cfq_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int WORD_W = 32;

    localparam logic signed [WORD_W-1:0] NEG_ONE = '1;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef logic [ADDR_W-1:0] idx_t;

    typedef enum logic {
        ST_IDLE,
        ST_POP
    } state_t;

    typedef struct packed {
        logic                     opcode;
        logic signed [WORD_W-1:0] data_word;
    } cmd_t;

    typedef struct packed {
        logic                     ok;
        logic signed [WORD_W-1:0] result_value;
        logic                     is_empty;
        logic                     is_full;
        logic signed [WORD_W-1:0] front_value;
        logic signed [WORD_W-1:0] rear_value;
    } rsp_t;

    // slot after i, wrapping at the last entry
    function automatic idx_t next_slot(input idx_t i);
        idx_t n;
        if (i == idx_t'(DEPTH - 1))
        begin
            n = '0;
        end
        else
        begin
            n = i + idx_t'(1);
        end
        return n;
    endfunction

endpackage

FILE: design/cfq_ram.sv
// ----------------------------------------------------------------------------
// cfq_ram
// Generic single-write, single-read synchronous ram with registered read.
// ----------------------------------------------------------------------------
module cfq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/cfq_ctrl.sv
// ----------------------------------------------------------------------------
// cfq_ctrl
// Queue sequencer: head/tail bookkeeping, ram access and result register.
// ----------------------------------------------------------------------------
module cfq_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_valid,
    output logic                             cmd_stall,
    input  cfq_pkg::cmd_t                    cmd,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output cfq_pkg::rsp_t                    rsp,
    output logic                             ram_we,
    output cfq_pkg::idx_t                    ram_waddr,
    output logic signed [cfq_pkg::WORD_W-1:0] ram_wdata,
    output cfq_pkg::idx_t                    ram_raddr,
    input  logic signed [cfq_pkg::WORD_W-1:0] ram_rdata
);

    cfq_pkg::state_t state_reg, state_next;
    cfq_pkg::idx_t   head_reg, head_next;
    cfq_pkg::idx_t   tail_reg, tail_next;
    logic            empty_reg, empty_next;
    logic signed [cfq_pkg::WORD_W-1:0] front_reg, front_next;
    logic signed [cfq_pkg::WORD_W-1:0] rear_reg, rear_next;
    cfq_pkg::rsp_t   rsp_reg, rsp_next;
    logic            rsp_valid_reg, rsp_valid_next;
    logic            accept;
    logic            full_now;

    assign cmd_stall = (state_reg != cfq_pkg::ST_IDLE) || (rsp_valid_reg && rsp_stall);
    assign accept    = cmd_valid && !cmd_stall;
    assign full_now  = !empty_reg && (cfq_pkg::next_slot(tail_reg) == head_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cfq_pkg::ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            empty_reg     <= 1'b1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            empty_reg     <= empty_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg <= front_next;
        rear_reg  <= rear_next;
        rsp_reg   <= rsp_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        empty_next     = empty_reg;
        front_next     = front_reg;
        rear_next      = rear_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        ram_we         = 1'b0;
        ram_waddr      = tail_reg;
        ram_wdata      = cmd.data_word;
        ram_raddr      = head_reg;

        unique case (state_reg)
            cfq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.opcode == cfq_pkg::OP_PUSH)
                    begin
                        if (full_now)
                        begin
                            rsp_next.ok           = 1'b0;
                            rsp_next.result_value = cfq_pkg::NEG_ONE;
                            rsp_next.is_empty     = 1'b0;
                            rsp_next.is_full      = 1'b1;
                            rsp_next.front_value  = front_reg;
                            rsp_next.rear_value   = rear_reg;
                        end
                        else
                        begin
                            if (empty_reg)
                            begin
                                head_next  = '0;
                                tail_next  = '0;
                                front_next = cmd.data_word;
                            end
                            else
                            begin
                                tail_next = cfq_pkg::next_slot(tail_reg);
                            end
                            ram_we     = 1'b1;
                            ram_waddr  = tail_next;
                            rear_next  = cmd.data_word;
                            empty_next = 1'b0;

                            rsp_next.ok           = 1'b1;
                            rsp_next.result_value = cmd.data_word;
                            rsp_next.is_empty     = 1'b0;
                            rsp_next.is_full      = cfq_pkg::next_slot(tail_next) == head_next;
                            rsp_next.front_value  = front_next;
                            rsp_next.rear_value   = cmd.data_word;
                        end
                        rsp_valid_next = 1'b1;
                    end
                    else if (empty_reg)
                    begin
                        rsp_next.ok           = 1'b0;
                        rsp_next.result_value = cfq_pkg::NEG_ONE;
                        rsp_next.is_empty     = 1'b1;
                        rsp_next.is_full      = 1'b0;
                        rsp_next.front_value  = cfq_pkg::NEG_ONE;
                        rsp_next.rear_value   = cfq_pkg::NEG_ONE;
                        rsp_valid_next        = 1'b1;
                    end
                    else
                    begin
                        if (head_reg == tail_reg)
                        begin
                            head_next  = '0;
                            tail_next  = '0;
                            empty_next = 1'b1;
                        end
                        else
                        begin
                            head_next = cfq_pkg::next_slot(head_reg);
                        end
                        // new front word arrives from the ram next cycle
                        ram_raddr = head_next;

                        rsp_next.ok           = 1'b1;
                        rsp_next.result_value = front_reg;
                        rsp_next.is_empty     = empty_next;
                        rsp_next.is_full      = !empty_next
                                                && (cfq_pkg::next_slot(tail_next) == head_next);
                        rsp_next.rear_value   = empty_next ? cfq_pkg::NEG_ONE : rear_reg;
                        state_next            = cfq_pkg::ST_POP;
                    end
                end
            end
            cfq_pkg::ST_POP:
            begin
                if (rsp_reg.is_empty)
                begin
                    rsp_next.front_value = cfq_pkg::NEG_ONE;
                end
                else
                begin
                    rsp_next.front_value = ram_rdata;
                    front_next           = ram_rdata;
                end
                rsp_valid_next = 1'b1;
                state_next     = cfq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = cfq_pkg::ST_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: design/circular_fifo_queue_core.sv
// ----------------------------------------------------------------------------
// circular_fifo_queue_core
// Circular fifo of signed 32-bit words with push/pop items and status result.
// ----------------------------------------------------------------------------
// Each item is a push or a pop and yields one result with ok, the pushed or
// popped word, empty/full status and the front and rear words afterwards.
// Pushes and refused operations need no ram read: the result is registered at
// the accepting edge and a new item can be taken in the next cycle. A
// successful pop passes through a pop state before its result is valid, as
// the word that becomes the new front is fetched through the storage ram's
// registered read port. The front and rear words are held in registers next
// to the ram, so no other operation reads it. Items are taken while no
// pop is under way and the result register is empty or drained that cycle.
module circular_fifo_queue_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  cfq_pkg::cmd_t cmd,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output cfq_pkg::rsp_t rsp
);

    logic                              ram_we;
    cfq_pkg::idx_t                     ram_waddr;
    cfq_pkg::idx_t                     ram_raddr;
    logic signed [cfq_pkg::WORD_W-1:0] ram_wdata;
    logic signed [cfq_pkg::WORD_W-1:0] ram_rdata;

    cfq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    cfq_ram #(
        .WIDTH (cfq_pkg::WORD_W),
        .DEPTH (cfq_pkg::DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

endmodule

FILE: design/cfq_checker.sv
// ----------------------------------------------------------------------------
// cfq_checker
// Port-level checks for the circular fifo queue core.
// ----------------------------------------------------------------------------
module cfq_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          cmd_stall,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input cfq_pkg::rsp_t rsp
);

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed");

    // refused item reports minus one
    a_refused_value: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.ok |-> rsp.result_value == cfq_pkg::NEG_ONE)
        else $error("refused item without minus one");

    // empty queue shows no front or rear word and cannot be full
    a_empty_view: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.is_empty |-> !rsp.is_full
            && rsp.front_value == cfq_pkg::NEG_ONE && rsp.rear_value == cfq_pkg::NEG_ONE)
        else $error("empty result inconsistent");

    // a waiting result blocks new items
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |-> cmd_stall)
        else $error("item taken while result stalled");

endmodule

bind circular_fifo_queue_core cfq_checker u_cfq_checker (.*);

FILE: verif/circular_fifo_queue_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_fifo_queue_core_tb
// Self-checking bench for the circular fifo queue core: push and pop items
// are predicted by a queue model and every result is compared field by field
// under random idling on both sides, a long receiver hold-off and drains.
// ----------------------------------------------------------------------------
module circular_fifo_queue_core_tb;
    import cfq_pkg::*;

    class queue_scoreboard;
        logic signed [WORD_W-1:0] slots [DEPTH];
        idx_t                     head_idx;
        idx_t                     tail_idx;
        bit                       holds_nothing;
        rsp_t                     expected_rsps [$];
        int                       mismatches;

        function new();
            head_idx      = '0;
            tail_idx      = '0;
            holds_nothing = 1'b1;
            mismatches    = 0;
        endfunction

        function idx_t slot_after(idx_t i);
            return idx_t'((int'(i) + 1) % DEPTH);
        endfunction

        function bit at_capacity();
            return !holds_nothing && slot_after(tail_idx) == head_idx;
        endfunction

        function int pending();
            return expected_rsps.size();
        endfunction

        // works out the result of one accepted item and queues it
        function void note_cmd(cmd_t c);
            rsp_t e;
            e.ok           = 1'b0;
            e.result_value = NEG_ONE;
            if (c.opcode == OP_PUSH)
            begin
                if (!at_capacity())
                begin
                    if (holds_nothing)
                    begin
                        head_idx = '0;
                        tail_idx = '0;
                    end
                    else
                    begin
                        tail_idx = slot_after(tail_idx);
                    end
                    slots[tail_idx] = c.data_word;
                    holds_nothing   = 1'b0;
                    e.ok            = 1'b1;
                    e.result_value  = c.data_word;
                end
            end
            else if (!holds_nothing)
            begin
                e.result_value = slots[head_idx];
                // popping the last entry puts both indices back at slot 0
                if (head_idx == tail_idx)
                begin
                    head_idx      = '0;
                    tail_idx      = '0;
                    holds_nothing = 1'b1;
                end
                else
                begin
                    head_idx = slot_after(head_idx);
                end
                e.ok = 1'b1;
            end
            e.is_empty    = holds_nothing;
            e.is_full     = at_capacity();
            e.front_value = holds_nothing ? NEG_ONE : slots[head_idx];
            e.rear_value  = holds_nothing ? NEG_ONE : slots[tail_idx];
            expected_rsps.push_back(e);
        endfunction

        task report(string msg);
            mismatches++;
            $display("%0t ns: %s", $time, msg);
        endtask

        task check_result(rsp_t r);
            rsp_t e;
            if (expected_rsps.size() == 0)
            begin
                report($sformatf("result with no item pending, value %h", r.result_value));
            end
            else
            begin
                e = expected_rsps.pop_front();
                if (r.ok !== e.ok)
                    report($sformatf("ok: got %b, expected %b", r.ok, e.ok));
                if (r.result_value !== e.result_value)
                    report($sformatf("result_value: got %h, expected %h",
                                     r.result_value, e.result_value));
                if (r.is_empty !== e.is_empty)
                    report($sformatf("is_empty: got %b, expected %b", r.is_empty, e.is_empty));
                if (r.is_full !== e.is_full)
                    report($sformatf("is_full: got %b, expected %b", r.is_full, e.is_full));
                if (r.front_value !== e.front_value)
                    report($sformatf("front_value: got %h, expected %h",
                                     r.front_value, e.front_value));
                if (r.rear_value !== e.rear_value)
                    report($sformatf("rear_value: got %h, expected %h",
                                     r.rear_value, e.rear_value));
            end
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_stall;
    cmd_t cmd;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    queue_scoreboard sb = new();
    int send_idle_pct = 0;
    int rsp_idle_pct  = 0;
    int hold_request  = 0;

    circular_fifo_queue_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("circular_fifo_queue_core test failed");
        $finish;
    end

    // receiver: takes results, stalls at random or for a requested hold-off
    initial
    begin
        int hold_left;
        hold_left = 0;
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
                sb.check_result(rsp);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
            end
        end
    end

    task send_cmd(logic op, logic signed [WORD_W-1:0] word);
        cmd_t c;
        c.opcode    = op;
        c.data_word = word;
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        sb.note_cmd(c);
    endtask

    task push(logic signed [WORD_W-1:0] word);
        send_cmd(OP_PUSH, word);
    endtask

    // data on a pop is ignored by the block but still toggled
    task pop();
        send_cmd(OP_POP, $urandom);
    endtask

    function logic signed [WORD_W-1:0] random_word();
        case ($urandom_range(7))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return '0;
            3: return NEG_ONE;
            default: return $urandom;
        endcase
    endfunction

    task wait_drained();
        cmd_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // bursts with a push bias each, so the queue swings between empty and full
    task run_random(int n);
        int left;
        int burst;
        int push_pct;
        left = n;
        while (left > 0)
        begin
            burst = $urandom_range(40, 4);
            case ($urandom_range(4))
                0: push_pct = 95;
                1: push_pct = 75;
                2: push_pct = 50;
                3: push_pct = 25;
                default: push_pct = 5;
            endcase
            for (int i = 0; i < burst && left > 0; i++)
            begin
                if ($urandom_range(99) < push_pct)
                    push(random_word());
                else
                    pop();
                left--;
            end
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        cmd       <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 16;
        rsp_idle_pct  = 70;

        // refused pop, extreme words, last-entry pop, reuse after empty
        pop();
        push(32'sh8000_0000);
        push(32'sh7fff_ffff);
        push('0);
        push(NEG_ONE);
        pop();
        pop();
        pop();
        pop();
        pop();
        push(32'sh5555_5555);
        push(32'shaaaa_aaaa);
        pop();
        push(32'sh0000_0001);
        pop();
        pop();
        pop();

        run_random(140);

        // sender pauses until everything is back, then a fill under hold-off
        wait_drained();
        while (!sb.holds_nothing)
            pop();
        hold_request = 60;
        for (int i = 0; i < DEPTH + 4; i++)
            push(random_word());
        wait_drained();

        send_idle_pct = 70;
        rsp_idle_pct  = 16;
        run_random(140);

        send_idle_pct = 0;
        rsp_idle_pct  = 0;
        run_random(140);

        wait_drained();
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("circular_fifo_queue_core test passed");
        end
        else
        begin
            $display("circular_fifo_queue_core test failed");
        end
        $finish;
    end

endmodule
